### src/mtc_pkg.sv
package mtc_pkg;

  // command codes
  typedef enum logic [2:0] {
    OP_TICK     = 3'd0,
    OP_START    = 3'd1,
    OP_STOP     = 3'd2,
    OP_CONTINUE = 3'd3,
    OP_LOCATE   = 3'd4
  } op_e;

  // transport state, one-hot
  typedef enum logic [4:0] {
    TS_NONE   = 5'b00001,
    TS_START  = 5'b00010,
    TS_STOP   = 5'b00100,
    TS_RUN    = 5'b01000,
    TS_LOCATE = 5'b10000
  } ts_e;

  // message bytes
  localparam logic [7:0] ByteSysexStart = 8'hf0;
  localparam logic [7:0] ByteSysexEnd   = 8'hf7;
  localparam logic [7:0] ByteQuarter    = 8'hf1;
  localparam logic [7:0] ByteRealtime   = 8'h7f;
  localparam logic [7:0] ByteMtcId      = 8'h01;

  // byte positions inside a message
  localparam int unsigned IdxW = 4;
  localparam logic [IdxW-1:0] FullLastIdx    = 4'd9;
  localparam logic [IdxW-1:0] QuarterLastIdx = 4'd1;

  // message queue geometry
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = 2;
  localparam int unsigned QCntW  = 3;

  // one queued message
  typedef struct packed {
    logic       is_full;
    logic [6:0] hr_byte;
    logic [5:0] minutes;
    logic [5:0] seconds;
    logic [4:0] frames;
    logic [7:0] qf_byte;
  } msg_t;

  // queue push request from the front
  typedef struct packed {
    logic push;
    msg_t msg;
  } push_t;

endpackage

### src/mtc_front.sv
module mtc_front import mtc_pkg::*; #(
  parameter int unsigned FramesPerSecond = 24
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [2:0] op_i,
  input  logic [4:0] locate_hours_i,
  input  logic [5:0] locate_minutes_i,
  input  logic [5:0] locate_seconds_i,
  input  logic [4:0] locate_frames_i,
  output push_t      push_o
);

  localparam logic [1:0] RateCode = (FramesPerSecond == 25) ? 2'd1 :
                                    (FramesPerSecond == 30) ? 2'd3 : 2'd0;
  localparam logic [5:0] Fps6     = 6'(FramesPerSecond);
  localparam logic [4:0] FrameMax = 5'(FramesPerSecond - 1);

  logic [4:0] hours_q, hours_d;
  logic [5:0] minutes_q, minutes_d;
  logic [5:0] seconds_q, seconds_d;
  logic [4:0] frames_q, frames_d;
  logic [2:0] qidx_q, qidx_d;
  ts_e        ts_q, ts_d;

  logic [4:0] base_h;
  logic [5:0] base_m;
  logic [5:0] base_s;
  logic [4:0] base_f;
  logic [5:0] f_inc;
  logic [4:0] f_wrap;
  logic [5:0] s_inc, s_wrap;
  logic [5:0] m_inc, m_wrap;
  logic [4:0] h_inc, h_wrap;
  logic [3:0] nibble;

  // playhead a tick works on: a pending start zeroes it
  always_comb begin
    if (ts_q == TS_START) begin
      base_h = '0;
      base_m = '0;
      base_s = '0;
      base_f = '0;
    end else begin
      base_h = hours_q;
      base_m = minutes_q;
      base_s = seconds_q;
      base_f = frames_q;
    end
  end

  // two-frame advance with carries
  always_comb begin
    f_inc = {1'b0, base_f} + 6'd2;
    s_inc = base_s;
    if (f_inc >= Fps6) begin
      f_wrap = 5'(f_inc - Fps6);
      s_inc  = base_s + 6'd1;
    end else begin
      f_wrap = f_inc[4:0];
    end
    m_inc = base_m;
    if (s_inc >= 6'd60) begin
      s_wrap = s_inc - 6'd60;
      m_inc  = base_m + 6'd1;
    end else begin
      s_wrap = s_inc;
    end
    h_inc = base_h;
    if (m_inc >= 6'd60) begin
      m_wrap = m_inc - 6'd60;
      h_inc  = base_h + 5'd1;
    end else begin
      m_wrap = m_inc;
    end
    if (h_inc >= 5'd24) begin
      h_wrap = h_inc - 5'd24;
    end else begin
      h_wrap = h_inc;
    end
  end

  // quarter-frame nibble
  always_comb begin
    unique case (qidx_q)
      3'd0:    nibble = base_f[3:0];
      3'd1:    nibble = {3'b000, base_f[4]};
      3'd2:    nibble = base_s[3:0];
      3'd3:    nibble = {2'b00, base_s[5:4]};
      3'd4:    nibble = base_m[3:0];
      3'd5:    nibble = {2'b00, base_m[5:4]};
      3'd6:    nibble = base_h[3:0];
      default: nibble = {1'b0, RateCode, base_h[4]};
    endcase
  end

  // command decode and state update
  always_comb begin
    hours_d   = hours_q;
    minutes_d = minutes_q;
    seconds_d = seconds_q;
    frames_d  = frames_q;
    qidx_d    = qidx_q;
    ts_d      = ts_q;

    push_o.push        = 1'b0;
    push_o.msg.is_full = 1'b0;
    push_o.msg.hr_byte = {RateCode, hours_q};
    push_o.msg.minutes = minutes_q;
    push_o.msg.seconds = seconds_q;
    push_o.msg.frames  = frames_q;
    push_o.msg.qf_byte = {1'b0, qidx_q, nibble};

    if (accept_i) begin
      unique case (op_e'(op_i))
        OP_START:    ts_d = TS_START;
        OP_STOP:     ts_d = TS_STOP;
        OP_CONTINUE: ts_d = TS_RUN;
        OP_LOCATE: begin
          hours_d   = (locate_hours_i > 5'd23) ? 5'd23 : locate_hours_i;
          minutes_d = (locate_minutes_i > 6'd59) ? 6'd59 : locate_minutes_i;
          seconds_d = (locate_seconds_i > 6'd59) ? 6'd59 : locate_seconds_i;
          frames_d  = (locate_frames_i > FrameMax) ? FrameMax : locate_frames_i;
          ts_d      = TS_LOCATE;
        end
        OP_TICK: begin
          if (ts_q == TS_LOCATE) begin
            push_o.push        = 1'b1;
            push_o.msg.is_full = 1'b1;
            ts_d               = TS_STOP;
          end else if (ts_q != TS_STOP) begin
            push_o.push = 1'b1;
            qidx_d      = qidx_q + 3'd1;
            if (qidx_q == 3'd7) begin
              hours_d   = h_wrap;
              minutes_d = m_wrap;
              seconds_d = s_wrap;
              frames_d  = f_wrap;
            end else begin
              hours_d   = base_h;
              minutes_d = base_m;
              seconds_d = base_s;
              frames_d  = base_f;
            end
            if (ts_q == TS_START) begin
              ts_d = TS_RUN;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hours_q   <= '0;
      minutes_q <= '0;
      seconds_q <= '0;
      frames_q  <= '0;
      qidx_q    <= '0;
      ts_q      <= TS_NONE;
    end else begin
      hours_q   <= hours_d;
      minutes_q <= minutes_d;
      seconds_q <= seconds_d;
      frames_q  <= frames_d;
      qidx_q    <= qidx_d;
      ts_q      <= ts_d;
    end
  end

endmodule

### src/mtc_queue.sv
module mtc_queue import mtc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  push_t push_i,
  input  logic  pop_i,
  output logic  full_o,
  output logic  valid_o,
  output msg_t  head_o
);

  msg_t             mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == QCntW'(QDepth));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_ptr_q];

  // pointer and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i.push) begin
      wr_ptr_d = wr_ptr_q + QPtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + QPtrW'(1);
    end
    if (push_i.push && !pop_i) begin
      cnt_d = cnt_q + QCntW'(1);
    end else if (!push_i.push && pop_i) begin
      cnt_d = cnt_q - QCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // message storage
  always_ff @(posedge clk_i) begin
    if (push_i.push) begin
      mem_q[wr_ptr_q] <= push_i.msg;
    end
  end

endmodule

### src/mtc_back.sv
module mtc_back import mtc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       head_valid_i,
  input  msg_t       head_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] midi_byte_o,
  output logic       last_byte_o
);

  logic [IdxW-1:0] idx_q, idx_d;
  logic            out_valid_q, out_valid_d;
  logic [7:0]      byte_q;
  logic            last_q;
  logic [7:0]      cur_byte;
  logic            cur_last;
  logic            load;

  // byte at the current position of the head message
  always_comb begin
    if (head_i.is_full) begin
      cur_last = (idx_q == FullLastIdx);
      unique case (idx_q)
        4'd0:    cur_byte = ByteSysexStart;
        4'd1:    cur_byte = ByteRealtime;
        4'd2:    cur_byte = ByteRealtime;
        4'd3:    cur_byte = ByteMtcId;
        4'd4:    cur_byte = ByteMtcId;
        4'd5:    cur_byte = {1'b0, head_i.hr_byte};
        4'd6:    cur_byte = {2'b00, head_i.minutes};
        4'd7:    cur_byte = {2'b00, head_i.seconds};
        4'd8:    cur_byte = {3'b000, head_i.frames};
        default: cur_byte = ByteSysexEnd;
      endcase
    end else begin
      cur_last = (idx_q == QuarterLastIdx);
      cur_byte = (idx_q == '0) ? ByteQuarter : head_i.qf_byte;
    end
  end

  // load the output register whenever a message is waiting and the register is free or being drained
  assign load  = head_valid_i && (!out_valid_q || out_ready_i);
  assign pop_o = load && cur_last;

  always_comb begin
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    if (load) begin
      idx_d       = cur_last ? '0 : idx_q + IdxW'(1);
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= cur_byte;
      last_q <= cur_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign midi_byte_o = byte_q;
  assign last_byte_o = last_q;

endmodule

### src/midi_time_code_generator.sv
// channel   direction  payload                                      handshake
// in        input      op, locate hours/minutes/seconds/frames      in_valid_i / in_ready_o
// out       output     midi_byte, last_byte                         out_valid_o / out_ready_i
//
// a command needs no wait state; ready drops only when the four-entry message queue is full
// a tick that emits queues one message; the back end sends one byte per cycle from it while
// out_ready_i is high, so a quarter frame is F1 then its data byte, a full frame SysEx F0 to F7
// the tick's message enters the queue, then its first byte loads into the output register
// reset clears the playhead, quarter index, transport state, queue and output valid flag
// output stalls back up into the queue and then into in_ready_o
module midi_time_code_generator import mtc_pkg::*; #(
  parameter int unsigned FramesPerSecond = 24
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [2:0] op_i,
  input  logic [4:0] locate_hours_i,
  input  logic [5:0] locate_minutes_i,
  input  logic [5:0] locate_seconds_i,
  input  logic [4:0] locate_frames_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] midi_byte_o,
  output logic       last_byte_o
);

  push_t push;
  logic  q_full;
  logic  q_valid;
  msg_t  q_head;
  logic  pop;
  logic  accept;

  assign in_ready_o = !q_full;
  assign accept     = in_valid_i && in_ready_o;

  // command decode and transport state
  mtc_front #(
    .FramesPerSecond(FramesPerSecond)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .op_i            (op_i),
    .locate_hours_i  (locate_hours_i),
    .locate_minutes_i(locate_minutes_i),
    .locate_seconds_i(locate_seconds_i),
    .locate_frames_i (locate_frames_i),
    .push_o          (push)
  );

  // message queue
  mtc_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pop_i  (pop),
    .full_o (q_full),
    .valid_o(q_valid),
    .head_o (q_head)
  );

  // byte serializer
  mtc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_valid_i(q_valid),
    .head_i      (q_head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .midi_byte_o (midi_byte_o),
    .last_byte_o (last_byte_o)
  );

  // a message is only queued for an accepted request
  assert property (@(posedge clk_i) disable iff (!rst_ni) push.push |-> accept)
    else $error("message queued without an accepted request");

  // never pop an empty queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop |-> q_valid)
    else $error("pop from empty message queue");

  // retiring a message loads its final byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |=> (out_valid_o && last_byte_o))
    else $error("message retired without presenting its last byte");

endmodule
